### src/qfts_pkg.sv
// Shared constants, types and codes for the two-stack byte queue.
// Used by qfts_ctrl, qfts_dp and queue_from_two_stacks_unit.
package qfts_pkg;

  localparam int STACK_DEPTH = 8;
  localparam int PTR_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int CNT_W = $clog2(STACK_DEPTH + 1);

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    KIND_ENQ = 1'b0,
    KIND_DEQ = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_MOVE,
    S_POPW
  } state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    load;         // capture the incoming transaction
    logic    push;         // push held byte onto input stack
    logic    pop;          // pop output stack, data lands in read register
    logic    mv;           // one step of the input-to-output transfer
    logic    res;          // write result registers
    logic    res_from_rd;  // result byte from output stack read
    status_t res_code;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    kind_t kind;
    logic  in_full;
    logic  in_zero;
    logic  out_zero;
    logic  mv_pend;
  } dp_stat_t;

endpackage

### src/qfts_ctrl.sv
// Controller state machine for the two-stack byte queue.
// Depends on qfts_pkg; drives qfts_dp through cmd_t, reads dp_stat_t.
module qfts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  qfts_pkg::dp_stat_t stat,
  output qfts_pkg::cmd_t    cmd
);

  qfts_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= qfts_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd = '0;
    cmd.res_code = qfts_pkg::ST_DONE;
    busy = (state != qfts_pkg::S_IDLE);
    unique case (state)
      qfts_pkg::S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_next = qfts_pkg::S_EXEC;
        end
      end
      qfts_pkg::S_EXEC: begin
        if (stat.kind == qfts_pkg::KIND_ENQ) begin
          cmd.push = !stat.in_full;
          cmd.res = 1'b1;
          cmd.res_code = stat.in_full ? qfts_pkg::ST_FULL : qfts_pkg::ST_DONE;
          state_next = qfts_pkg::S_IDLE;
        end else if (stat.in_zero && stat.out_zero) begin
          cmd.res = 1'b1;
          cmd.res_code = qfts_pkg::ST_EMPTY;
          state_next = qfts_pkg::S_IDLE;
        end else if (stat.out_zero) begin
          state_next = qfts_pkg::S_MOVE;
        end else begin
          cmd.pop = 1'b1;
          state_next = qfts_pkg::S_POPW;
        end
      end
      qfts_pkg::S_MOVE: begin
        cmd.mv = 1'b1;
        // last write has landed once the input stack is drained
        if (stat.in_zero && !stat.mv_pend) begin
          state_next = qfts_pkg::S_EXEC;
        end
      end
      qfts_pkg::S_POPW: begin
        cmd.res = 1'b1;
        cmd.res_from_rd = 1'b1;
        state_next = qfts_pkg::S_IDLE;
      end
      default: begin
        state_next = qfts_pkg::S_IDLE;
      end
    endcase
  end

endmodule

### src/qfts_dp.sv
// Datapath for the two-stack byte queue: both stack memories, their
// counts, the transfer pipeline and the result registers. Uses qfts_pkg.
module qfts_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               kind,
  input  logic [7:0]         in_byte,
  input  qfts_pkg::cmd_t     cmd,
  output qfts_pkg::dp_stat_t stat,
  output logic [7:0]         out_byte,
  output logic [1:0]         status,
  output logic               now_empty,
  output logic               now_full,
  output logic               done
);

  logic [7:0] in_mem  [qfts_pkg::STACK_DEPTH];
  logic [7:0] out_mem [qfts_pkg::STACK_DEPTH];

  logic [qfts_pkg::CNT_W-1:0] in_cnt, in_cnt_next;
  logic [qfts_pkg::CNT_W-1:0] out_cnt, out_cnt_next;
  logic [qfts_pkg::CNT_W-1:0] in_m1, out_m1;
  logic                       kind_q;
  logic [7:0]                 byte_q;
  logic [7:0]                 in_rd;
  logic [7:0]                 out_rd;
  logic                       mv_pend;
  logic                       mv_rd;
  logic                       in_zero, out_zero, in_full;

  assign in_zero  = (in_cnt == '0);
  assign out_zero = (out_cnt == '0);
  assign in_full  = (in_cnt == qfts_pkg::CNT_W'(qfts_pkg::STACK_DEPTH));
  assign in_m1    = in_cnt - qfts_pkg::CNT_W'(1);
  assign out_m1   = out_cnt - qfts_pkg::CNT_W'(1);
  assign mv_rd    = cmd.mv && !in_zero;

  assign stat.kind     = qfts_pkg::kind_t'(kind_q);
  assign stat.in_full  = in_full;
  assign stat.in_zero  = in_zero;
  assign stat.out_zero = out_zero;
  assign stat.mv_pend  = mv_pend;

  always_comb begin
    in_cnt_next = in_cnt;
    out_cnt_next = out_cnt;
    if (cmd.push) begin
      in_cnt_next = in_cnt + qfts_pkg::CNT_W'(1);
    end else if (mv_rd) begin
      in_cnt_next = in_m1;
    end
    if (cmd.pop) begin
      out_cnt_next = out_m1;
    end else if (cmd.mv && mv_pend) begin
      out_cnt_next = out_cnt + qfts_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_q <= kind;
      byte_q <= in_byte;
    end
  end

  // input stack memory
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      in_mem[in_cnt[qfts_pkg::PTR_W-1:0]] <= byte_q;
    end
    if (mv_rd) begin
      in_rd <= in_mem[in_m1[qfts_pkg::PTR_W-1:0]];
    end
  end

  // output stack memory; transfer write lands in the cycle after its read
  always_ff @(posedge clk) begin
    if (cmd.mv && mv_pend) begin
      out_mem[out_cnt[qfts_pkg::PTR_W-1:0]] <= in_rd;
    end
    if (cmd.pop) begin
      out_rd <= out_mem[out_m1[qfts_pkg::PTR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      out_cnt <= '0;
      mv_pend <= 1'b0;
      done    <= 1'b0;
    end else begin
      in_cnt  <= in_cnt_next;
      out_cnt <= out_cnt_next;
      mv_pend <= mv_rd;
      done    <= cmd.res;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res) begin
      out_byte  <= cmd.res_from_rd ? out_rd : 8'd0;
      status    <= cmd.res_code;
      now_empty <= (in_cnt_next == '0) && (out_cnt_next == '0);
      now_full  <= (in_cnt_next == qfts_pkg::CNT_W'(qfts_pkg::STACK_DEPTH));
    end
  end

endmodule

### src/queue_from_two_stacks_unit.sv
// Top level of the two-stack byte queue: controller plus datapath.
// Depends on qfts_pkg, qfts_ctrl and qfts_dp.
//
//   channel   ports                                  transaction
//   command   start, busy, kind, in_byte             start && !busy at clk edge
//   result    done, out_byte, status, now_empty,     done high for one cycle
//             now_full
//
// Enqueue, and dequeue on an empty queue, finish in S_EXEC; dequeue on a
// non-empty output stack pops in S_EXEC and finishes in S_POPW. A dequeue
// that finds the output stack empty first moves the input stack over, one
// byte per cycle through the stack memory read ports, then pops it.
// rst is synchronous and empties both stacks. Results cannot be stalled;
// busy drops in the cycle done is high, so the next command can follow.
module queue_from_two_stacks_unit (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic       kind,
  input  logic [7:0] in_byte,
  output logic       done,
  output logic [7:0] out_byte,
  output logic [1:0] status,
  output logic       now_empty,
  output logic       now_full
);

  qfts_pkg::cmd_t     cmd;
  qfts_pkg::dp_stat_t stat;

  qfts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  qfts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .kind      (kind),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .stat      (stat),
    .out_byte  (out_byte),
    .status    (status),
    .now_empty (now_empty),
    .now_full  (now_full),
    .done      (done)
  );

endmodule

### dv/tb.sv
// Testbench for queue_from_two_stacks_unit: directed table, then biased random traffic,
// every result checked against an in-bench two-stack queue predictor or a fixed directed expectation.
// Depends on qfts_pkg and the RTL of queue_from_two_stacks_unit.
module tb;

  localparam int TOTAL_ITEMS    = 1050;
  localparam int BURST_LEN      = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 30;

  typedef struct packed {
    logic [7:0]        data;
    qfts_pkg::status_t code;
    logic              empty;
    logic              full;
  } qresult_t;

  typedef struct {
    qfts_pkg::kind_t op;
    logic [7:0]      b;
    bit              typed;
    qresult_t        exp;
  } stim_row_t;

  logic       clk;
  logic       rst;
  logic       start;
  logic       busy;
  logic       kind;
  logic [7:0] in_byte;
  logic       done;
  logic [7:0] out_byte;
  logic [1:0] status;
  logic       now_empty;
  logic       now_full;

  // predictor state
  logic [7:0] push_lifo [qfts_pkg::STACK_DEPTH];
  logic [7:0] pop_lifo  [qfts_pkg::STACK_DEPTH];
  int         push_cnt;
  int         pop_cnt;

  qresult_t   pending_results [$];
  stim_row_t  dir_rows [$];
  int         errors;
  int         idle_cycles;

  queue_from_two_stacks_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .kind      (kind),
    .in_byte   (in_byte),
    .done      (done),
    .out_byte  (out_byte),
    .status    (status),
    .now_empty (now_empty),
    .now_full  (now_full)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic qresult_t mk_result(logic [7:0] d, qfts_pkg::status_t c,
                                         logic e, logic f);
    qresult_t r;
    r.data  = d;
    r.code  = c;
    r.empty = e;
    r.full  = f;
    return r;
  endfunction

  function void clear_queue_model();
    push_cnt = 0;
    pop_cnt  = 0;
  endfunction

  // Enqueue pushes the input stack; dequeue pops the output stack, refilling it
  // from the input stack (reversed) only when it has run dry.
  function qresult_t predict_queue_op(qfts_pkg::kind_t op, logic [7:0] b);
    qresult_t r;
    r = mk_result(8'h00, qfts_pkg::ST_DONE, 1'b0, 1'b0);
    if (op == qfts_pkg::KIND_ENQ) begin
      if (push_cnt < qfts_pkg::STACK_DEPTH) begin
        push_lifo[push_cnt] = b;
        push_cnt++;
      end else begin
        r.code = qfts_pkg::ST_FULL;
      end
    end else if (push_cnt == 0 && pop_cnt == 0) begin
      r.code = qfts_pkg::ST_EMPTY;
    end else begin
      if (pop_cnt == 0) begin
        while (push_cnt > 0) begin
          push_cnt--;
          pop_lifo[pop_cnt] = push_lifo[push_cnt];
          pop_cnt++;
        end
      end
      pop_cnt--;
      r.data = pop_lifo[pop_cnt];
    end
    r.empty = (push_cnt == 0 && pop_cnt == 0);
    r.full  = (push_cnt >= qfts_pkg::STACK_DEPTH);
    return r;
  endfunction

  function void add_row(qfts_pkg::kind_t op, logic [7:0] b, bit typed, qresult_t exp);
    stim_row_t row;
    row.op    = op;
    row.b     = b;
    row.typed = typed;
    row.exp   = exp;
    dir_rows.push_back(row);
  endfunction

  // One transaction: optional drain pause and idle gap, then hold start until accepted.
  // start stays high after acceptance so back-to-back commands need no extra edge.
  task automatic issue_cmd(qfts_pkg::kind_t op, logic [7:0] b, int gap, bit drain,
                           bit typed, qresult_t exp);
    qresult_t pred;
    @(negedge clk);
    if (gap != 0 || drain) begin
      start <= 1'b0;
      if (drain) begin
        @(negedge clk);
        while (pending_results.size() != 0) @(negedge clk);
      end
      repeat (gap) @(negedge clk);
    end
    start   <= 1'b1;
    kind    <= op;
    in_byte <= b;
    do @(posedge clk); while (busy);
    pred = predict_queue_op(op, b);
    pending_results.push_back(typed ? exp : pred);
  endtask

  // result checker
  always @(posedge clk) begin
    qresult_t got;
    qresult_t want;
    if (!rst && done) begin
      got = mk_result(out_byte, qfts_pkg::status_t'(status), now_empty, now_full);
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: byte %02h status %0d empty %0b full %0b",
                 $time, got.data, got.code, got.empty, got.full);
      end else begin
        want = pending_results.pop_front();
        if (got != want) begin
          errors++;
          $display({"%0t: mismatch: expected byte %02h status %0d empty %0b full %0b,",
                    " got byte %02h status %0d empty %0b full %0b"},
                   $time, want.data, want.code, want.empty, want.full,
                   got.data, got.code, got.empty, got.full);
        end
      end
    end
  end

  // watchdog: cycles with no transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  initial begin
    int              sent;
    int              enq_pct;
    bit              fast_burst;
    bit              drain;
    int              gap;
    qfts_pkg::kind_t op;
    logic [7:0]      b;
    qresult_t        none;

    rst     = 1'b1;
    start   = 1'b0;
    kind    = 1'b0;
    in_byte = 8'h00;
    errors  = 0;
    none    = mk_result(8'h00, qfts_pkg::ST_DONE, 1'b0, 1'b0);
    clear_queue_model();

    // dequeue on an empty queue right after reset
    add_row(qfts_pkg::KIND_DEQ, 8'h00, 1'b1,
            mk_result(8'h00, qfts_pkg::ST_EMPTY, 1'b1, 1'b0));
    // fill the input stack with byte extremes
    add_row(qfts_pkg::KIND_ENQ, 8'h00, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'hFF, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h01, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h80, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h55, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'hAA, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h7F, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'hFE, 1'b0, none);
    // refused while full
    add_row(qfts_pkg::KIND_ENQ, 8'h12, 1'b1,
            mk_result(8'h00, qfts_pkg::ST_FULL, 1'b0, 1'b1));
    // dequeue moves all eight over; oldest comes out
    add_row(qfts_pkg::KIND_DEQ, 8'hFF, 1'b1,
            mk_result(8'h00, qfts_pkg::ST_DONE, 1'b0, 1'b0));
    // refill input stack while the output stack still holds seven
    add_row(qfts_pkg::KIND_ENQ, 8'hC3, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h3C, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h0F, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'hF0, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h99, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h66, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'h24, 1'b0, none);
    add_row(qfts_pkg::KIND_ENQ, 8'hDB, 1'b0, none);
    // refused although the output stack has room
    add_row(qfts_pkg::KIND_ENQ, 8'hE7, 1'b1,
            mk_result(8'h00, qfts_pkg::ST_FULL, 1'b0, 1'b1));
    // no transfer: output stack still non-empty
    add_row(qfts_pkg::KIND_DEQ, 8'h00, 1'b1,
            mk_result(8'hFF, qfts_pkg::ST_DONE, 1'b0, 1'b1));
    add_row(qfts_pkg::KIND_DEQ, 8'h5A, 1'b0, none);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    sent = 0;
    foreach (dir_rows[i]) begin
      issue_cmd(dir_rows[i].op, dir_rows[i].b, $urandom_range(0, 15), 1'b0,
                dir_rows[i].typed, dir_rows[i].exp);
      sent++;
    end

    enq_pct    = 50;
    fast_burst = 1'b0;
    drain      = 1'b1;  // first random command waits for the directed results to drain
    while (sent < TOTAL_ITEMS) begin
      if (sent % BURST_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 15;
          1:       enq_pct = 50;
          default: enq_pct = 85;
        endcase
        fast_burst = ($urandom_range(0, 3) == 0);
        if ($urandom_range(0, 3) == 0) drain = 1'b1;
      end
      op   = ($urandom_range(0, 99) < enq_pct) ? qfts_pkg::KIND_ENQ : qfts_pkg::KIND_DEQ;
      b    = 8'($urandom_range(0, 255));
      gap  = fast_burst ? 0 : $urandom_range(0, 15);
      issue_cmd(op, b, gap, drain, 1'b0, none);
      drain = 1'b0;
      sent++;
    end

    @(negedge clk);
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

### queue_from_two_stacks_unit.f
src/qfts_pkg.sv
src/qfts_ctrl.sv
src/qfts_dp.sv
src/queue_from_two_stacks_unit.sv
dv/tb.sv
